### src/pidc_pkg.sv
package pidc_pkg;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 31;
   localparam int GAIN_W = 16;
   localparam int LIMIT_W = 31;

   localparam logic [CSR_IDX_W-1:0] CSR_P_GAIN       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_I_GAIN       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_D_GAIN       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_I_ENABLE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_D_ENABLE     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_LIMIT = 3'd5;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

   typedef struct packed {
      logic [GAIN_W-1:0]  p_gain;
      logic [GAIN_W-1:0]  i_gain;
      logic [GAIN_W-1:0]  d_gain;
      logic               i_enable;
      logic               d_enable;
      logic [LIMIT_W-1:0] output_limit;
   } cfg_type;

   // error stage: error, saturated error sum, error difference
   typedef struct packed {
      logic [16:0] error;
      logic [31:0] error_sum;
      logic [17:0] error_diff;
   } err_type;

   // products already shifted right by 8
   typedef struct packed {
      logic [24:0] p_scaled;
      logic [39:0] i_scaled;
      logic [25:0] d_scaled;
   } prod_type;

   typedef struct packed {
      logic [24:0] p_term;
      logic [31:0] i_term;
      logic [31:0] d_term;
   } term_type;

   function automatic logic [31:0] clamp_sym(input logic [41:0] v, input logic [LIMIT_W-1:0] lim);
      logic signed [41:0] hi;
      logic signed [41:0] lo;
      hi = $signed({11'd0, lim});
      lo = -hi;
      if ($signed(v) > hi) begin
         clamp_sym = hi[31:0];
      end else if ($signed(v) < lo) begin
         clamp_sym = lo[31:0];
      end else begin
         clamp_sym = v[31:0];
      end
   endfunction

endpackage

### src/pidc_err.sv
module pidc_err (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [15:0]       target,
   input  logic [15:0]       measured,
   output logic              out_valid,
   input  logic              out_ready,
   output pidc_pkg::err_type out_data
);
   import pidc_pkg::*;

   localparam logic [31:0] ESUM_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] ESUM_MIN = 32'h8000_0000;

   logic        vld_ff;
   err_type     data_ff;
   err_type     data_in;
   logic [31:0] error_sum_ff;
   logic [31:0] error_sum_in;
   logic [16:0] last_error_ff;
   logic [16:0] error;
   logic [32:0] sum_wide;
   logic        accept;

   assign in_ready = !vld_ff || out_ready;
   assign accept = in_valid && in_ready;

   always_comb begin
      error = {target[15], target} - {measured[15], measured};
      sum_wide = {error_sum_ff[31], error_sum_ff} + {{16{error[16]}}, error};
      // saturate when the carry into the sign disagrees
      if (sum_wide[32] != sum_wide[31]) begin
         error_sum_in = sum_wide[32] ? ESUM_MIN : ESUM_MAX;
      end else begin
         error_sum_in = sum_wide[31:0];
      end
      data_in.error = error;
      data_in.error_sum = error_sum_in;
      data_in.error_diff = {error[16], error} - {last_error_ff[16], last_error_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         error_sum_ff <= '0;
         last_error_ff <= '0;
      end else begin
         if (in_ready) begin
            vld_ff <= in_valid;
         end
         if (accept) begin
            error_sum_ff <= error_sum_in;
            last_error_ff <= error;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data = data_ff;

`ifndef SYNTHESIS
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(error_sum_ff) && $stable(last_error_ff))
      else $error("pid state changed without an accepted beat");
   a_state_matches_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> data_ff.error_sum == error_sum_ff && data_ff.error == last_error_ff)
      else $error("error stage and pid state disagree");
   a_sum_saturates_high: assert property (@(posedge clock) disable iff (reset)
      accept && error_sum_ff == ESUM_MAX && !error[16] |=> error_sum_ff == ESUM_MAX)
      else $error("error sum left positive saturation");
`endif

endmodule

### src/pidc_mult.sv
module pidc_mult (
   input  logic               clock,
   input  logic               reset,
   input  pidc_pkg::cfg_type  cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  pidc_pkg::err_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output pidc_pkg::prod_type out_data
);
   import pidc_pkg::*;

   logic               vld_ff;
   prod_type           data_ff;
   prod_type           data_in;
   logic signed [32:0] p_prod;
   logic signed [47:0] i_prod;
   logic signed [33:0] d_prod;

   assign in_ready = !vld_ff || out_ready;

   always_comb begin
      p_prod = $signed(in_data.error) * $signed(cfg.p_gain);
      i_prod = $signed(in_data.error_sum) * $signed(cfg.i_gain);
      d_prod = $signed(in_data.error_diff) * $signed(cfg.d_gain);
      // arithmetic shift right by 8 is floor division by 256
      data_in.p_scaled = p_prod[32:8];
      data_in.i_scaled = i_prod[47:8];
      data_in.d_scaled = d_prod[33:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data = data_ff;

endmodule

### src/pidc_clamp.sv
module pidc_clamp (
   input  logic               clock,
   input  logic               reset,
   input  pidc_pkg::cfg_type  cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  pidc_pkg::prod_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output pidc_pkg::term_type out_data
);
   import pidc_pkg::*;

   logic     vld_ff;
   term_type data_ff;
   term_type data_in;

   assign in_ready = !vld_ff || out_ready;

   always_comb begin
      data_in.p_term = in_data.p_scaled;
      data_in.i_term = clamp_sym({{2{in_data.i_scaled[39]}}, in_data.i_scaled}, cfg.output_limit);
      data_in.d_term = clamp_sym({{16{in_data.d_scaled[25]}}, in_data.d_scaled},
                                 cfg.output_limit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data = data_ff;

endmodule

### src/pidc_out.sv
module pidc_out (
   input  logic               clock,
   input  logic               reset,
   input  pidc_pkg::cfg_type  cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  pidc_pkg::term_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [127:0]       out_data
);
   import pidc_pkg::*;

   logic         vld_ff;
   logic [127:0] data_ff;
   logic [127:0] data_in;
   logic [33:0]  sum;
   logic [31:0]  drive;
   logic [31:0]  p_ext;

   assign in_ready = !vld_ff || out_ready;

   always_comb begin
      p_ext = {{7{in_data.p_term[24]}}, in_data.p_term};
      sum = {{9{in_data.p_term[24]}}, in_data.p_term};
      if (cfg.i_enable) begin
         sum = sum + {{2{in_data.i_term[31]}}, in_data.i_term};
      end
      if (cfg.d_enable) begin
         sum = sum + {{2{in_data.d_term[31]}}, in_data.d_term};
      end
      drive = clamp_sym({{8{sum[33]}}, sum}, cfg.output_limit);
      data_in = {in_data.d_term, in_data.i_term, p_ext, drive};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data = data_ff;

endmodule

### src/pid_controller_clamped.sv
// channel  dir  handshake                    payload
// req      in   req_tvalid / req_tready      target, measured
// rsp      out  rsp_tvalid / rsp_tready      drive, p_term, i_term, d_term
// csr      in   csr_we (no wait)             csr_index, csr_wdata
//
// one beat in and one beat out per cycle when both sides keep up
// a beat passes in order through the error stage, multiply stage, clamp stage and output register
// the error sum and last error update in the cycle a req beat is taken
// each stage holds its beat while the next is full, so req keeps flowing into empty stages
// synchronous reset clears the valid bits, the pid state and the csr registers to reset values
module pid_controller_clamped (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [31:0]                      req_tdata,  // target, measured
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [127:0]                     rsp_tdata,  // drive, p_term, i_term, d_term
   input  logic                             csr_we,
   input  logic [pidc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pidc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pidc_pkg::*;

   cfg_type  cfg_ff;
   logic     err_valid;
   logic     err_ready;
   err_type  err_data;
   logic     prod_valid;
   logic     prod_ready;
   prod_type prod_data;
   logic     term_valid;
   logic     term_ready;
   term_type term_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.p_gain <= '0;
         cfg_ff.i_gain <= '0;
         cfg_ff.d_gain <= '0;
         cfg_ff.i_enable <= 1'b0;
         cfg_ff.d_enable <= 1'b0;
         cfg_ff.output_limit <= LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_P_GAIN: begin
               cfg_ff.p_gain <= csr_wdata[GAIN_W-1:0];
            end
            CSR_I_GAIN: begin
               cfg_ff.i_gain <= csr_wdata[GAIN_W-1:0];
            end
            CSR_D_GAIN: begin
               cfg_ff.d_gain <= csr_wdata[GAIN_W-1:0];
            end
            CSR_I_ENABLE: begin
               cfg_ff.i_enable <= csr_wdata[0];
            end
            CSR_D_ENABLE: begin
               cfg_ff.d_enable <= csr_wdata[0];
            end
            CSR_OUTPUT_LIMIT: begin
               cfg_ff.output_limit <= csr_wdata[LIMIT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   pidc_err u_err (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .target    (req_tdata[15:0]),
      .measured  (req_tdata[31:16]),
      .out_valid (err_valid),
      .out_ready (err_ready),
      .out_data  (err_data)
   );

   pidc_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (err_valid),
      .in_ready  (err_ready),
      .in_data   (err_data),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_data  (prod_data)
   );

   pidc_clamp u_clamp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_data   (prod_data),
      .out_valid (term_valid),
      .out_ready (term_ready),
      .out_data  (term_data)
   );

   pidc_out u_out (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (term_valid),
      .in_ready  (term_ready),
      .in_data   (term_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

`ifndef SYNTHESIS
   a_drive_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         $signed({rsp_tdata[31], rsp_tdata[31:0]}) <= $signed({2'b00, cfg_ff.output_limit}) &&
         $signed({rsp_tdata[31], rsp_tdata[31:0]}) >= -$signed({2'b00, cfg_ff.output_limit}))
      else $error("drive outside output limit");
   a_id_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         $signed({rsp_tdata[95], rsp_tdata[95:64]}) <= $signed({2'b00, cfg_ff.output_limit}) &&
         $signed({rsp_tdata[127], rsp_tdata[127:96]}) <= $signed({2'b00, cfg_ff.output_limit}))
      else $error("integral or derivative term above output limit");
   a_zero_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && cfg_ff.output_limit == '0 |->
         rsp_tdata[31:0] == '0 && rsp_tdata[127:64] == '0)
      else $error("zero limit did not force clamped outputs to zero");
`endif

endmodule
